### src/assert_macros.svh
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/rtc_sca_pkg.sv
// Shared types, register codes and reset constants of the RTC seconds counter.
`timescale 1ns / 1ps

package rtc_sca_pkg;

    // Default configuration
    localparam int SYNC_TICKS_DEF    = 3;
    localparam int PRESCALE_BITS_DEF = 20;

    // Full width of the prescaler register view on the bus
    localparam int PRE_VIEW_W = 20;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Register indexes
    localparam logic [3:0] REG_CRH  = 4'd0;
    localparam logic [3:0] REG_CRL  = 4'd1;
    localparam logic [3:0] REG_PRLH = 4'd2;
    localparam logic [3:0] REG_PRLL = 4'd3;
    localparam logic [3:0] REG_DIVH = 4'd4;
    localparam logic [3:0] REG_DIVL = 4'd5;
    localparam logic [3:0] REG_CNTH = 4'd6;
    localparam logic [3:0] REG_CNTL = 4'd7;
    localparam logic [3:0] REG_ALRH = 4'd8;
    localparam logic [3:0] REG_ALRL = 4'd9;

    // Flag and enable bit positions
    localparam int FLAG_SEC = 0;
    localparam int FLAG_ALR = 1;
    localparam int FLAG_OVF = 2;

    // CRL control bit positions
    localparam int CRL_SYNC = 3;
    localparam int CRL_CNF  = 4;

    // Reset values
    localparam logic [PRE_VIEW_W-1:0] PRESCALE_RESET = 20'h07FFF;
    localparam logic [31:0]           ALARM_RESET    = 32'hFFFF_FFFF;

    // One incoming transfer
    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  reg_index;
        logic [15:0] write_data;
    } t_item;

    // One outgoing transfer
    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_line;
        logic        alarm_line;
    } t_result;

endpackage

### src/rtc_sca_core.sv
// Register file, prescaler, seconds counter and alarm compare of the RTC.
`timescale 1ns / 1ps

module rtc_sca_core #(
    parameter int SYNC_TICKS    = rtc_sca_pkg::SYNC_TICKS_DEF,
    parameter int PRESCALE_BITS = rtc_sca_pkg::PRESCALE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  rtc_sca_pkg::t_item   i_item,
    output rtc_sca_pkg::t_result o_result
);

    localparam int VW = rtc_sca_pkg::PRE_VIEW_W;

    logic [2:0]               r_int_en,  n_int_en;
    logic [2:0]               r_flags,   n_flags;
    logic                     r_sync,    n_sync;
    logic                     r_cfg,     n_cfg;
    logic [1:0]               r_busy,    n_busy;
    logic [PRESCALE_BITS-1:0] r_reload,  n_reload;
    logic [PRESCALE_BITS-1:0] r_div,     n_div;
    logic [31:0]              r_cnt,     n_cnt;
    logic [31:0]              r_alarm,   n_alarm;

    logic [31:0]   cnt_inc;
    logic [VW-1:0] reload_view;
    logic [VW-1:0] div_view;
    logic [15:0]   rd_data;

    assign cnt_inc     = r_cnt + 32'd1;
    assign reload_view = VW'(r_reload);
    assign div_view    = VW'(r_div);

    // Work out the state after this transfer and the read data
    always_comb begin
        n_int_en = r_int_en;
        n_flags  = r_flags;
        n_sync   = r_sync;
        n_cfg    = r_cfg;
        n_busy   = r_busy;
        n_reload = r_reload;
        n_div    = r_div;
        n_cnt    = r_cnt;
        n_alarm  = r_alarm;
        rd_data  = 16'd0;
        case (i_item.req_type)
            rtc_sca_pkg::REQ_TICK: begin
                // Count down; on rollover reload and advance the seconds
                if (r_div == '0) begin
                    n_div = r_reload;
                    n_cnt = cnt_inc;
                    n_flags[rtc_sca_pkg::FLAG_SEC] = 1'b1;
                    if (cnt_inc == 32'd0) begin
                        n_flags[rtc_sca_pkg::FLAG_OVF] = 1'b1;
                    end
                    if (cnt_inc == r_alarm) begin
                        n_flags[rtc_sca_pkg::FLAG_ALR] = 1'b1;
                    end
                end else begin
                    n_div = r_div - PRESCALE_BITS'(1);
                end
                n_sync = 1'b1;
                if (r_busy != 2'd0) begin
                    n_busy = r_busy - 2'd1;
                end
            end
            rtc_sca_pkg::REQ_WRITE: begin
                case (i_item.reg_index)
                    rtc_sca_pkg::REG_CRH: begin
                        n_int_en = i_item.write_data[2:0];
                    end
                    rtc_sca_pkg::REG_CRL: begin
                        // Writing zero clears a flag; leaving config mode starts write-off
                        n_flags = r_flags & i_item.write_data[2:0];
                        if (!i_item.write_data[rtc_sca_pkg::CRL_SYNC]) begin
                            n_sync = 1'b0;
                        end
                        if (r_cfg && !i_item.write_data[rtc_sca_pkg::CRL_CNF]) begin
                            n_busy = 2'(SYNC_TICKS);
                        end
                        n_cfg = i_item.write_data[rtc_sca_pkg::CRL_CNF];
                    end
                    rtc_sca_pkg::REG_PRLH: begin
                        if (r_cfg) begin
                            n_reload = PRESCALE_BITS'({i_item.write_data[3:0],
                                                       reload_view[15:0]});
                        end
                    end
                    rtc_sca_pkg::REG_PRLL: begin
                        if (r_cfg) begin
                            n_reload = PRESCALE_BITS'({reload_view[VW-1:16],
                                                       i_item.write_data});
                        end
                    end
                    rtc_sca_pkg::REG_CNTH: begin
                        if (r_cfg) begin
                            n_cnt = {i_item.write_data, r_cnt[15:0]};
                        end
                    end
                    rtc_sca_pkg::REG_CNTL: begin
                        if (r_cfg) begin
                            n_cnt = {r_cnt[31:16], i_item.write_data};
                        end
                    end
                    rtc_sca_pkg::REG_ALRH: begin
                        if (r_cfg) begin
                            n_alarm = {i_item.write_data, r_alarm[15:0]};
                        end
                    end
                    rtc_sca_pkg::REG_ALRL: begin
                        if (r_cfg) begin
                            n_alarm = {r_alarm[31:16], i_item.write_data};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rtc_sca_pkg::REQ_READ: begin
                case (i_item.reg_index)
                    rtc_sca_pkg::REG_CRH:  rd_data = {13'd0, r_int_en};
                    rtc_sca_pkg::REG_CRL:  rd_data = {10'd0, (r_busy == 2'd0), r_cfg,
                                                      r_sync, r_flags};
                    rtc_sca_pkg::REG_PRLH: rd_data = 16'(reload_view[VW-1:16]);
                    rtc_sca_pkg::REG_PRLL: rd_data = reload_view[15:0];
                    rtc_sca_pkg::REG_DIVH: rd_data = 16'(div_view[VW-1:16]);
                    rtc_sca_pkg::REG_DIVL: rd_data = div_view[15:0];
                    rtc_sca_pkg::REG_CNTH: rd_data = r_cnt[31:16];
                    rtc_sca_pkg::REG_CNTL: rd_data = r_cnt[15:0];
                    rtc_sca_pkg::REG_ALRH: rd_data = r_alarm[31:16];
                    rtc_sca_pkg::REG_ALRL: rd_data = r_alarm[15:0];
                    default:               rd_data = 16'd0;
                endcase
            end
            default: begin
            end
        endcase
    end

    // Result lines reflect the state after the update
    assign o_result.read_data  = rd_data;
    assign o_result.irq_line   = |(n_flags & n_int_en);
    assign o_result.alarm_line = n_flags[rtc_sca_pkg::FLAG_ALR]
                               & n_int_en[rtc_sca_pkg::FLAG_ALR];

    // Commit the new state when the transfer is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_en <= 3'd0;
            r_flags  <= 3'd0;
            r_sync   <= 1'b0;
            r_cfg    <= 1'b0;
            r_busy   <= 2'd0;
            r_reload <= PRESCALE_BITS'(rtc_sca_pkg::PRESCALE_RESET);
            r_div    <= PRESCALE_BITS'(rtc_sca_pkg::PRESCALE_RESET);
            r_cnt    <= 32'd0;
            r_alarm  <= rtc_sca_pkg::ALARM_RESET;
        end else if (i_fire) begin
            r_int_en <= n_int_en;
            r_flags  <= n_flags;
            r_sync   <= n_sync;
            r_cfg    <= n_cfg;
            r_busy   <= n_busy;
            r_reload <= n_reload;
            r_div    <= n_div;
            r_cnt    <= n_cnt;
            r_alarm  <= n_alarm;
        end
    end

endmodule

### src/rtc_seconds_counter_alarm.sv
// Top level of the RTC: input register, register-file core and result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   request | in        | i_valid / o_stall  | i_req_type, i_reg_index, i_write_data
//   result  | out       | o_valid / i_stall  | o_read_data, o_irq_line, o_alarm_line
//
// One request per clock while o_stall is low; each request is captured in the input register,
// updated by the core, and its result is then captured in the result register.
// Reset (synchronous, active low) empties both registers and loads the RTC reset state.
// A stalled result holds; a request waiting behind it raises o_stall until the result moves.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtc_seconds_counter_alarm #(
    parameter int SYNC_TICKS    = rtc_sca_pkg::SYNC_TICKS_DEF,
    parameter int PRESCALE_BITS = rtc_sca_pkg::PRESCALE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_reg_index,
    input  logic [15:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_data,
    output logic        o_irq_line,
    output logic        o_alarm_line
);

    logic                 r_in_vld;
    rtc_sca_pkg::t_item   r_item;
    logic                 r_out_vld;
    rtc_sca_pkg::t_result r_res;
    rtc_sca_pkg::t_result core_res;
    logic                 out_blocked;
    logic                 fire;
    logic                 in_load;

    // Hold the request while the result register is full and stalled
    assign out_blocked = r_out_vld & i_stall;
    assign fire        = r_in_vld & !out_blocked;
    assign o_stall     = r_in_vld & out_blocked;
    assign in_load     = !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_load) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_item.req_type   <= i_req_type;
            r_item.reg_index  <= i_reg_index;
            r_item.write_data <= i_write_data;
        end
    end

    rtc_sca_core #(
        .SYNC_TICKS    (SYNC_TICKS),
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .o_result (core_res)
    );

    // Result register: load on a processed request, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!out_blocked) begin
            r_out_vld <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_read_data  = r_res.read_data;
    assign o_irq_line   = r_res.irq_line;
    assign o_alarm_line = r_res.alarm_line;

    // A waiting request survives a stalled result
    `ASSERT_NEXT(a_req_kept, i_clk, i_rst_n, r_in_vld && out_blocked, r_in_vld)
    // A new result only follows a request held in the input register
    `ASSERT_SAME(a_res_has_src, i_clk, i_rst_n, $rose(o_valid), $past(r_in_vld))
    // The alarm line is one of the interrupt sources
    `ASSERT_SAME(a_alarm_in_irq, i_clk, i_rst_n, o_valid && o_alarm_line, o_irq_line)

endmodule
